// File: rtl/core/hslrgb_pkg.sv
// ----------------------------------------------------------------------------
// hslrgb_pkg
// Types and constants shared by the HSL to RGB converter.
// ----------------------------------------------------------------------------
package hslrgb_pkg;

    // Payload of one conversion request
    typedef struct packed {
        logic signed [15:0] hue_degrees;
        logic [6:0]         saturation_pct;
        logic [6:0]         lightness_pct;
    } hsl_req_t;

    // One converted color
    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
    } rgb_res_t;

    localparam int HUE_CIRCLE = 360;
    localparam int SECTOR_DEG = 60;
    localparam int PCT_FULL   = 100;
    localparam int PCT_DOUBLE = 200;
    localparam int CHAN_MAX   = 255;

    // 92 * 360: lifts any 16-bit hue to a positive 17-bit value, same residue
    localparam int HUE_OFFSET = 92 * HUE_CIRCLE;
    // floor(x / 360) = (x * HUE_RECIP) >> HUE_SHIFT for x < 2^17
    localparam int HUE_SHIFT  = 25;
    localparam int HUE_RECIP  = ((1 << HUE_SHIFT) + HUE_CIRCLE - 1) / HUE_CIRCLE;

    // Channel = floor(255 * v / 1200000) = floor(17 * v / 80000)
    localparam int CHAN_MUL   = 17;
    localparam int CHAN_DEN   = 80000;
    // 80000 = 2^7 * 625
    localparam int DEN_SHIFT  = 7;
    localparam int DEN_ODD    = CHAN_DEN >> DEN_SHIFT;
    localparam int ODD_SHIFT  = 27;
    localparam int ODD_RECIP  = ((1 << ODD_SHIFT) + DEN_ODD - 1) / DEN_ODD;
    // Smallest v whose channel value exceeds 255
    localparam int CHAN_SAT   =
        ((CHAN_MAX + 1) * CHAN_DEN + CHAN_MUL - 1) / CHAN_MUL;

    localparam int PIPE_DEPTH = 5;

endpackage

// File: rtl/core/hsl_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// hsl_to_rgb_converter
// Converts hue / saturation / lightness to 8-bit RGB in a five-stage pipeline.
// ----------------------------------------------------------------------------
//  Channel   Ports              Direction  Handshake
//  ---------------------------------------------------------------------
//  request   start, request     in         accepted when start && !busy
//  result    done, result       out        valid for one cycle while done
//
//  done rises as the last stage registers the result, which is taken at the
//  rising edge where done is high; a new request may be issued every cycle.
//  The five register stages are hue multiply, sector pick, channel numerators,
//  scaling, reciprocal divide.
//  busy stays low: the receiver cannot stall, so nothing ever backs up.
//  Reset clears the stage valid bits only; requests in flight are dropped.
module hsl_to_rgb_converter
    import hslrgb_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  hsl_req_t request,
    output logic     done,
    output rgb_res_t result
);

    typedef enum logic [2:0] {
        SEC_RY, // red max, green rising
        SEC_YG, // green max, red falling
        SEC_GC, // green max, blue rising
        SEC_CB, // blue max, green falling
        SEC_BM, // blue max, red rising
        SEC_MR  // red max, blue falling
    } sector_t;

    logic [PIPE_DEPTH-1:0] valid_reg;
    logic [PIPE_DEPTH-1:0] valid_next;

    // ---------------- stage 1: hue reciprocal product, S*D ----------------
    logic [16:0]        hue_lift;
    logic signed [8:0]  light_t;
    logic [7:0]         light_abs;
    logic signed [8:0]  chroma_span;
    logic signed [15:0] sd_c;

    logic [16:0]        hx_reg;
    logic [33:0]        hprod_reg;
    logic signed [15:0] sd1_reg;
    logic [6:0]         l1_reg;

    always_comb
    begin
        hue_lift    = {request.hue_degrees[15], request.hue_degrees}
                    + 17'(HUE_OFFSET);
        light_t     = $signed({1'b0, request.lightness_pct, 1'b0}) - 9'(PCT_FULL);
        light_abs   = light_t[8] ? 8'(-light_t) : light_t[7:0];
        chroma_span = 9'(PCT_FULL) - $signed({1'b0, light_abs});
        sd_c        = $signed({9'b0, request.saturation_pct})
                    * {{7{chroma_span[8]}}, chroma_span};
    end

    always_ff @(posedge clk)
    begin
        hx_reg    <= hue_lift;
        hprod_reg <= {17'b0, hue_lift} * 34'(HUE_RECIP);
        sd1_reg   <= sd_c;
        l1_reg    <= request.lightness_pct;
    end

    // ---------------- stage 2: hue residue, sector, base ----------------
    logic [8:0]         hq;
    logic [16:0]        hrem_w;
    logic [8:0]         hrem;
    sector_t            sec_c;
    logic [8:0]         fpos_w;
    logic signed [17:0] base_c;

    sector_t            sec2_reg;
    logic [5:0]         f2_reg;
    logic signed [17:0] base2_reg;
    logic signed [15:0] sd2_reg;

    always_comb
    begin
        hq     = hprod_reg[33:HUE_SHIFT];
        hrem_w = hx_reg - 17'(hq) * 17'(HUE_CIRCLE);
        hrem   = hrem_w[8:0];
        if (hrem < 9'(SECTOR_DEG))
        begin
            sec_c  = SEC_RY;
            fpos_w = hrem;
        end
        else if (hrem < 9'(2 * SECTOR_DEG))
        begin
            sec_c  = SEC_YG;
            fpos_w = 9'(2 * SECTOR_DEG) - hrem;
        end
        else if (hrem < 9'(3 * SECTOR_DEG))
        begin
            sec_c  = SEC_GC;
            fpos_w = hrem - 9'(2 * SECTOR_DEG);
        end
        else if (hrem < 9'(4 * SECTOR_DEG))
        begin
            sec_c  = SEC_CB;
            fpos_w = 9'(4 * SECTOR_DEG) - hrem;
        end
        else if (hrem < 9'(5 * SECTOR_DEG))
        begin
            sec_c  = SEC_BM;
            fpos_w = hrem - 9'(4 * SECTOR_DEG);
        end
        else
        begin
            sec_c  = SEC_MR;
            fpos_w = 9'(HUE_CIRCLE) - hrem;
        end
        base_c = $signed({11'b0, l1_reg}) * 18'(PCT_DOUBLE)
               - {{2{sd1_reg[15]}}, sd1_reg};
    end

    always_ff @(posedge clk)
    begin
        sec2_reg  <= sec_c;
        f2_reg    <= fpos_w[5:0];
        base2_reg <= base_c;
        sd2_reg   <= sd1_reg;
    end

    // ---------------- stage 3: channel numerators ----------------
    logic signed [23:0] b60;
    logic signed [23:0] sd_ext;
    logic signed [23:0] v_max;
    logic signed [23:0] v_min;
    logic signed [23:0] v_mid;
    logic signed [23:0] v_c [3];
    logic signed [23:0] v3_reg [3];

    always_comb
    begin
        b60    = {{6{base2_reg[17]}}, base2_reg} * 24'(SECTOR_DEG);
        sd_ext = {{8{sd2_reg[15]}}, sd2_reg};
        v_min  = b60;
        v_max  = b60 + sd_ext * 24'(2 * SECTOR_DEG);
        v_mid  = b60 + sd_ext * $signed({17'b0, f2_reg, 1'b0});
        unique case (sec2_reg)
            SEC_RY:  v_c = '{v_max, v_mid, v_min};
            SEC_YG:  v_c = '{v_mid, v_max, v_min};
            SEC_GC:  v_c = '{v_min, v_max, v_mid};
            SEC_CB:  v_c = '{v_min, v_mid, v_max};
            SEC_BM:  v_c = '{v_mid, v_min, v_max};
            SEC_MR:  v_c = '{v_max, v_min, v_mid};
            default: v_c = '{v_min, v_min, v_min};
        endcase
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
            v3_reg[i] <= v_c[i];
    end

    // ---------------- stage 4: scale by 17, strip 2^7, clamp flags ----------
    logic [29:0] y_c [3];
    logic [17:0] z4_reg [3];
    logic        pos4_reg [3];
    logic        sat4_reg [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            y_c[i] = 30'(v3_reg[i]) * 30'(CHAN_MUL);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            z4_reg[i]   <= y_c[i][DEN_SHIFT +: 18];
            pos4_reg[i] <= (v3_reg[i] > 24'sd0);
            sat4_reg[i] <= (v3_reg[i] >= 24'(CHAN_SAT));
        end
    end

    // ---------------- stage 5: divide by 625, final clamp ----------------
    logic [35:0] p_c [3];
    logic [7:0]  ch_c [3];
    rgb_res_t    result_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            p_c[i] = {18'b0, z4_reg[i]} * 36'(ODD_RECIP);
            if (!pos4_reg[i])
                ch_c[i] = 8'd0;
            else if (sat4_reg[i])
                ch_c[i] = 8'(CHAN_MAX);
            else
                ch_c[i] = p_c[i][ODD_SHIFT +: 8];
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg.red_out   <= ch_c[0];
        result_reg.green_out <= ch_c[1];
        result_reg.blue_out  <= ch_c[2];
    end

    // ---------------- valid bits ----------------
    assign valid_next = {valid_reg[PIPE_DEPTH-2:0], start};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign busy   = 1'b0;
    assign done   = valid_reg[PIPE_DEPTH-1];
    assign result = result_reg;

    // ---------------- assertions ----------------
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##5 done)
        else $error("request did not complete after five cycles");

    a_black: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && request.lightness_pct == 7'd0 |-> ##5
        (result.red_out == 8'd0 && result.green_out == 8'd0
         && result.blue_out == 8'd0))
        else $error("zero lightness gave a non-black color");

    a_gray: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && request.saturation_pct == 7'd0 |-> ##5
        (result.red_out == result.green_out
         && result.green_out == result.blue_out))
        else $error("zero saturation gave unequal channels");

endmodule

// File: tb/tb_hsl_to_rgb_converter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hsl_to_rgb_converter
// Self-checking bench for the HSL to RGB converter. A directed set covers the
// sector edges, hue wrap, gray/black/white and out-of-range percentages. Random
// colors with random request gaps follow, and each result is checked against
// an exact integer prediction.
// ----------------------------------------------------------------------------
module tb_hsl_to_rgb_converter;
    import hslrgb_pkg::*;

    localparam int     RANDOM_COLORS = 830;
    localparam longint SCALE_DEN     = 1200000;  // 60 deg * 200 * 100

    // Holds predicted colors in request order and checks results against them
    class color_scoreboard;
        rgb_res_t   expected_colors[$];
        hsl_req_t   pending_requests[$];
        int         mismatches;
        int         colors_checked;

        // Exact channel value between min (f = 0) and max (f = 60), floored
        function logic [7:0] channel_level(longint base, longint spread, longint f);
            longint num;
            longint q;
            num = CHAN_MAX * (SECTOR_DEG * base + 2 * spread * f);
            if (num <= 0)
                return 8'd0;
            q = num / SCALE_DEN;
            if (q > CHAN_MAX)
                q = CHAN_MAX;
            return q[7:0];
        endfunction

        function rgb_res_t predict_rgb(hsl_req_t req);
            int         hue;
            longint     sat;
            longint     lit;
            longint     lit_dev;
            longint     spread;
            longint     base;
            logic [7:0] cmax;
            logic [7:0] cmin;
            rgb_res_t   rgb;
            hue = $signed(req.hue_degrees);
            hue = hue % HUE_CIRCLE;
            if (hue < 0)
                hue += HUE_CIRCLE;
            sat     = req.saturation_pct;
            lit     = req.lightness_pct;
            lit_dev = 2 * lit - PCT_FULL;
            if (lit_dev < 0)
                lit_dev = -lit_dev;
            // saturation * chroma span; goes negative for lightness above 100
            spread = sat * (PCT_FULL - lit_dev);
            base   = PCT_DOUBLE * lit - spread;
            cmax   = channel_level(base, spread, SECTOR_DEG);
            cmin   = channel_level(base, spread, 0);
            if (hue < 60)
                rgb = '{cmax, channel_level(base, spread, hue), cmin};
            else if (hue < 120)
                rgb = '{channel_level(base, spread, 120 - hue), cmax, cmin};
            else if (hue < 180)
                rgb = '{cmin, cmax, channel_level(base, spread, hue - 120)};
            else if (hue < 240)
                rgb = '{cmin, channel_level(base, spread, 240 - hue), cmax};
            else if (hue < 300)
                rgb = '{channel_level(base, spread, hue - 240), cmin, cmax};
            else
                rgb = '{cmax, cmin, channel_level(base, spread, 360 - hue)};
            return rgb;
        endfunction

        function void note_request(hsl_req_t req);
            expected_colors.push_back(predict_rgb(req));
            pending_requests.push_back(req);
        endfunction

        function int pending();
            return expected_colors.size();
        endfunction

        task report(string what);
            $display("[%0t] MISMATCH %s", $realtime, what);
            mismatches++;
        endtask

        task check_color(rgb_res_t got);
            rgb_res_t exp_rgb;
            hsl_req_t req;
            if (expected_colors.size() == 0)
            begin
                report($sformatf("result %0d/%0d/%0d with no request pending",
                                 got.red_out, got.green_out, got.blue_out));
                return;
            end
            exp_rgb = expected_colors.pop_front();
            req     = pending_requests.pop_front();
            colors_checked++;
            if (got.red_out !== exp_rgb.red_out)
                report($sformatf("red h=%0d s=%0d l=%0d: got %0d expected %0d",
                                 $signed(req.hue_degrees), req.saturation_pct,
                                 req.lightness_pct, got.red_out, exp_rgb.red_out));
            if (got.green_out !== exp_rgb.green_out)
                report($sformatf("green h=%0d s=%0d l=%0d: got %0d expected %0d",
                                 $signed(req.hue_degrees), req.saturation_pct,
                                 req.lightness_pct, got.green_out, exp_rgb.green_out));
            if (got.blue_out !== exp_rgb.blue_out)
                report($sformatf("blue h=%0d s=%0d l=%0d: got %0d expected %0d",
                                 $signed(req.hue_degrees), req.saturation_pct,
                                 req.lightness_pct, got.blue_out, exp_rgb.blue_out));
        endtask
    endclass

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    hsl_req_t color_req;
    logic     done;
    rgb_res_t color_res;

    color_scoreboard sb;
    int              colors_sent;
    int              negative_hues;
    int              over_range;
    int              drains;

    hsl_to_rgb_converter dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (color_req),
        .done    (done),
        .result  (color_res)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_color(color_res);
    end

    function hsl_req_t make_hsl(int hue, int sat, int lit);
        hsl_req_t req;
        req.hue_degrees    = hue[15:0];
        req.saturation_pct = sat[6:0];
        req.lightness_pct  = lit[6:0];
        return req;
    endfunction

    function hsl_req_t random_hsl();
        int hue;
        int sat;
        int lit;
        if ($urandom_range(0, 9) < 7)
            hue = int'($urandom_range(0, 1439)) - 720;
        else
            hue = $urandom;
        if ($urandom_range(0, 4) != 0)
        begin
            sat = $urandom_range(0, 100);
            lit = $urandom_range(0, 100);
        end
        else
        begin
            sat = $urandom_range(0, 127);
            lit = $urandom_range(0, 127);
        end
        return make_hsl(hue, sat, lit);
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    task send_hsl(hsl_req_t req, int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start     <= 1'b1;
        color_req <= req;
        do
            @(posedge clk);
        while (busy);
        sb.note_request(req);
        colors_sent++;
        if ($signed(req.hue_degrees) < 0)
            negative_hues++;
        if (req.saturation_pct > PCT_FULL || req.lightness_pct > PCT_FULL)
            over_range++;
        @(negedge clk);
    endtask

    // Hold off new requests until every outstanding color has come back
    task drain_pipeline();
        start <= 1'b0;
        do
            @(negedge clk);
        while (sb.pending() != 0);
        drains++;
    endtask

    initial
    begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        hsl_req_t directed[$];
        int       gap_mode;
        int       gap;

        sb        = new();
        clk       = 1'b0;
        rst_n     = 1'b0;
        start     = 1'b0;
        color_req = '0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // primaries and sector edges on both sides
        directed = {make_hsl(0, 100, 50),   make_hsl(59, 100, 50),
                    make_hsl(60, 100, 50),  make_hsl(119, 100, 50),
                    make_hsl(120, 100, 50), make_hsl(179, 100, 50),
                    make_hsl(180, 100, 50), make_hsl(239, 100, 50),
                    make_hsl(240, 100, 50), make_hsl(299, 100, 50),
                    make_hsl(300, 100, 50), make_hsl(359, 100, 50),
                    // hue wrap, both directions and 16-bit extremes
                    make_hsl(360, 100, 50), make_hsl(-1, 100, 50),
                    make_hsl(-360, 80, 40), make_hsl(-32768, 100, 50),
                    make_hsl(32767, 100, 50),
                    // gray, black, white
                    make_hsl(30, 0, 50),    make_hsl(200, 50, 0),
                    make_hsl(200, 50, 100),
                    // percentages past 100 (negative span, clamping), lightness 99
                    make_hsl(90, 127, 50),  make_hsl(150, 60, 127),
                    make_hsl(330, 127, 127), make_hsl(45, 127, 0),
                    make_hsl(15, 100, 99)};
        foreach (directed[i])
            send_hsl(directed[i], (i % 3 == 0) ? 0 : $urandom_range(0, 9));
        drain_pipeline();

        gap_mode = 0;
        for (int n = 0; n < RANDOM_COLORS; n++)
        begin
            // new traffic pattern every 40 colors: back-to-back or random gaps
            if (n % 40 == 0)
                gap_mode = $urandom_range(0, 2);
            gap = (gap_mode == 0) ? 0 : $urandom_range(0, 9);
            send_hsl(random_hsl(), gap);
            if (n % 200 == 199 || $urandom_range(0, 99) == 0)
                drain_pipeline();
        end

        drain_pipeline();
        repeat (PIPE_DEPTH + 5) @(posedge clk);

        if (sb.pending() != 0)
            sb.report($sformatf("%0d colors never came back", sb.pending()));

        $display("Converted %0d colors, %0d checked, %0d pipeline drains.",
                 colors_sent, sb.colors_checked, drains);
        $display("Covered %0d negative hues and %0d requests above 100 percent.",
                 negative_hues, over_range);
        if (sb.mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
